FILE: hw/rtl/lruhc_pkg.sv
// ----------------------------------------------------------------------------
// lruhc_pkg
// Shared sizes, operation codes and controller/datapath interface types
// for the fully associative LRU handle cache.
// ----------------------------------------------------------------------------
package lruhc_pkg;

  localparam int CAPACITY   = 1024;
  localparam int KEY_BITS   = 64;
  localparam int SLOT_W     = $clog2(CAPACITY);
  localparam int OCC_W      = $clog2(CAPACITY + 1);
  localparam int FUNC_W     = 2;
  localparam int KEY_PORT_W = 64;
  localparam int SLOT_OUT_W = 10;
  localparam int OCC_OUT_W  = 11;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_ACQUIRE = 2'd0,
    FUNC_RELEASE = 2'd1,
    FUNC_CLEAR   = 2'd2,
    FUNC_NOP     = 2'd3
  } func_t;

  typedef struct packed {
    logic load;        // capture the accepted item
    logic clr_start;   // start a sweep that invalidates every entry
    logic scan_start;  // start the tag search sweep
    logic upd_start;   // start the rank update sweep
    logic decide;      // resolve target slot and counters from the search
    logic emit;        // register and strobe the result
  } lruhc_cmd_t;

  typedef struct packed {
    logic  pass_busy;
    logic  hit;
    func_t func;
  } lruhc_sts_t;

endpackage

FILE: hw/rtl/lruhc_datapath.sv
// ----------------------------------------------------------------------------
// lruhc_datapath
// Tag and metadata memories, sweep address counter, search capture,
// rank update logic, occupancy counter and result registers.
// ----------------------------------------------------------------------------
module lruhc_datapath (
  input  logic                               clk,
  input  logic                               rst_n,
  input  lruhc_pkg::lruhc_cmd_t              cmd,
  output lruhc_pkg::lruhc_sts_t              sts,
  input  logic [lruhc_pkg::FUNC_W-1:0]       in_func,
  input  logic [lruhc_pkg::KEY_PORT_W-1:0]   in_key,
  output logic                               out_valid,
  output logic                               out_found,
  output logic [lruhc_pkg::SLOT_OUT_W-1:0]   out_slot,
  output logic                               out_evicted,
  output logic [lruhc_pkg::KEY_PORT_W-1:0]   out_evicted_key,
  output logic [lruhc_pkg::OCC_OUT_W-1:0]    out_occupancy
);
  import lruhc_pkg::*;

  typedef enum logic [1:0] {
    P_NONE,
    P_CLEAR,
    P_SEARCH,
    P_UPDATE
  } pass_t;

  typedef struct packed {
    logic              valid;
    logic [SLOT_W-1:0] rank;
  } meta_t;

  localparam logic [SLOT_W-1:0] LAST_ADDR   = SLOT_W'(CAPACITY - 1);
  localparam logic [SLOT_W-1:0] LRU_RANK    = SLOT_W'(CAPACITY - 1);
  localparam logic [SLOT_W:0]   LIMIT_ALL   = (SLOT_W + 1)'(CAPACITY);
  localparam logic [SLOT_W:0]   LIMIT_EVICT = (SLOT_W + 1)'(CAPACITY - 1);
  localparam logic [OCC_W-1:0]  COUNT_FULL  = OCC_W'(CAPACITY);

  logic [KEY_BITS-1:0] key_mem  [CAPACITY];
  meta_t               meta_mem [CAPACITY];

  // sweep control
  pass_t             pass_r;
  logic              issue_r;
  logic [SLOT_W-1:0] addr_r;
  logic              rd_vld_r;
  logic [SLOT_W-1:0] rd_idx_r;
  logic              rd_en;

  // read data
  logic [KEY_BITS-1:0] key_q_r;
  meta_t               meta_q_r;

  // item
  func_t               func_r;
  logic [KEY_BITS-1:0] key_r;

  // search results
  logic                hit_r;
  logic [SLOT_W-1:0]   hit_slot_r;
  logic [SLOT_W-1:0]   hit_rank_r;
  logic                free_fnd_r;
  logic [SLOT_W-1:0]   free_slot_r;
  logic                lru_fnd_r;
  logic [SLOT_W-1:0]   lru_slot_r;
  logic [KEY_BITS-1:0] lru_key_r;

  // decision
  logic                found_r;
  logic [SLOT_W-1:0]   tgt_r;
  logic [SLOT_W:0]     limit_r;
  logic                evict_r;
  logic [KEY_BITS-1:0] evkey_r;
  logic [OCC_W-1:0]    count_r;

  logic                found_nxt;
  logic [SLOT_W-1:0]   tgt_nxt;
  logic [SLOT_W:0]     limit_nxt;
  logic                evict_nxt;
  logic [KEY_BITS-1:0] evkey_nxt;
  logic [OCC_W-1:0]    count_nxt;

  // memory write port
  logic              meta_we;
  logic              key_we;
  logic [SLOT_W-1:0] waddr;
  meta_t             wmeta;
  logic [SLOT_W:0]   rank_ext;

  // result registers
  logic                  out_valid_r;
  logic                  out_found_r;
  logic [SLOT_W-1:0]     out_slot_r;
  logic                  out_evicted_r;
  logic [KEY_BITS-1:0]   out_evkey_r;
  logic [OCC_W-1:0]      out_occ_r;
  logic [KEY_PORT_W-1:0] evkey_ext;
  logic [SLOT_W+SLOT_OUT_W-1:0] slot_ext;
  logic [OCC_W+OCC_OUT_W-1:0]   occ_ext;

  assign rd_en    = issue_r && (pass_r != P_CLEAR);
  assign rank_ext = {1'b0, meta_q_r.rank};

  // decision from the search sweep
  always_comb begin
    found_nxt = 1'b0;
    tgt_nxt   = '0;
    limit_nxt = '0;
    evict_nxt = 1'b0;
    evkey_nxt = '0;
    count_nxt = count_r;
    unique case (func_r)
      FUNC_ACQUIRE: begin
        if (hit_r) begin
          found_nxt = 1'b1;
          tgt_nxt   = hit_slot_r;
          limit_nxt = {1'b0, hit_rank_r};
        end else if (count_r == COUNT_FULL) begin
          tgt_nxt   = lru_slot_r;
          limit_nxt = LIMIT_EVICT;
          evict_nxt = 1'b1;
          evkey_nxt = lru_key_r;
        end else begin
          tgt_nxt   = free_slot_r;
          limit_nxt = LIMIT_ALL;
          count_nxt = count_r + OCC_W'(1);
        end
      end
      FUNC_RELEASE: begin
        if (hit_r) begin
          found_nxt = 1'b1;
          tgt_nxt   = hit_slot_r;
          limit_nxt = {1'b0, hit_rank_r};
          count_nxt = count_r - OCC_W'(1);
        end
      end
      FUNC_CLEAR: begin
        count_nxt = '0;
      end
      FUNC_NOP: begin
        count_nxt = count_r;
      end
      default: begin
        count_nxt = count_r;
      end
    endcase
  end

  // write port: clear sweep writes at issue, update sweep writes back read data
  always_comb begin
    meta_we = 1'b0;
    key_we  = 1'b0;
    waddr   = addr_r;
    wmeta   = '0;
    if (pass_r == P_CLEAR && issue_r) begin
      meta_we = 1'b1;
    end else if (pass_r == P_UPDATE && rd_vld_r) begin
      meta_we = 1'b1;
      waddr   = rd_idx_r;
      wmeta   = meta_q_r;
      if (func_r == FUNC_ACQUIRE) begin
        if (rd_idx_r == tgt_r) begin
          key_we      = 1'b1;
          wmeta.valid = 1'b1;
          wmeta.rank  = '0;
        end else if (meta_q_r.valid && rank_ext < limit_r) begin
          wmeta.rank = meta_q_r.rank + SLOT_W'(1);
        end
      end else begin
        if (rd_idx_r == tgt_r) begin
          wmeta.valid = 1'b0;
        end else if (meta_q_r.valid && rank_ext > limit_r) begin
          wmeta.rank = meta_q_r.rank - SLOT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (meta_we) begin
      meta_mem[waddr] <= wmeta;
    end
    if (key_we) begin
      key_mem[waddr] <= key_r;
    end
    if (rd_en) begin
      key_q_r  <= key_mem[addr_r];
      meta_q_r <= meta_mem[addr_r];
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pass_r      <= P_NONE;
      issue_r     <= 1'b0;
      addr_r      <= '0;
      rd_vld_r    <= 1'b0;
      hit_r       <= 1'b0;
      free_fnd_r  <= 1'b0;
      lru_fnd_r   <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      rd_vld_r    <= rd_en;
      out_valid_r <= cmd.emit;
      if (cmd.clr_start || cmd.scan_start || cmd.upd_start) begin
        issue_r <= 1'b1;
        addr_r  <= '0;
        if (cmd.clr_start) begin
          pass_r <= P_CLEAR;
        end else if (cmd.scan_start) begin
          pass_r <= P_SEARCH;
        end else begin
          pass_r <= P_UPDATE;
        end
      end else if (issue_r) begin
        addr_r <= addr_r + SLOT_W'(1);
        if (addr_r == LAST_ADDR) begin
          issue_r <= 1'b0;
        end
      end
      if (cmd.scan_start) begin
        hit_r      <= 1'b0;
        free_fnd_r <= 1'b0;
        lru_fnd_r  <= 1'b0;
      end else if (pass_r == P_SEARCH && rd_vld_r) begin
        if (meta_q_r.valid && key_q_r == key_r) begin
          hit_r <= 1'b1;
        end
        if (!meta_q_r.valid) begin
          free_fnd_r <= 1'b1;
        end
        if (meta_q_r.valid && meta_q_r.rank == LRU_RANK) begin
          lru_fnd_r <= 1'b1;
        end
      end
      if (cmd.decide) begin
        count_r <= count_nxt;
      end
    end
  end

  // payload registers; first match wins for each search capture
  always_ff @(posedge clk) begin
    rd_idx_r <= addr_r;
    if (cmd.load) begin
      func_r <= func_t'(in_func);
      key_r  <= in_key[KEY_BITS-1:0];
    end
    if (pass_r == P_SEARCH && rd_vld_r) begin
      if (!hit_r && meta_q_r.valid && key_q_r == key_r) begin
        hit_slot_r <= rd_idx_r;
        hit_rank_r <= meta_q_r.rank;
      end
      if (!free_fnd_r && !meta_q_r.valid) begin
        free_slot_r <= rd_idx_r;
      end
      if (!lru_fnd_r && meta_q_r.valid && meta_q_r.rank == LRU_RANK) begin
        lru_slot_r <= rd_idx_r;
        lru_key_r  <= key_q_r;
      end
    end
    if (cmd.decide) begin
      found_r <= found_nxt;
      tgt_r   <= tgt_nxt;
      limit_r <= limit_nxt;
      evict_r <= evict_nxt;
      evkey_r <= evkey_nxt;
    end
    if (cmd.emit) begin
      out_found_r   <= found_r;
      out_slot_r    <= tgt_r;
      out_evicted_r <= evict_r;
      out_evkey_r   <= evkey_r;
      out_occ_r     <= count_r;
    end
  end

  always_comb begin
    evkey_ext                = '0;
    evkey_ext[KEY_BITS-1:0]  = out_evkey_r;
  end

  assign slot_ext = {{SLOT_OUT_W{1'b0}}, out_slot_r};
  assign occ_ext  = {{OCC_OUT_W{1'b0}}, out_occ_r};

  assign out_valid       = out_valid_r;
  assign out_found       = out_found_r;
  assign out_slot        = slot_ext[SLOT_OUT_W-1:0];
  assign out_evicted     = out_evicted_r;
  assign out_evicted_key = evkey_ext;
  assign out_occupancy   = occ_ext[OCC_OUT_W-1:0];

  assign sts.pass_busy = issue_r || rd_vld_r;
  assign sts.hit       = hit_r;
  assign sts.func      = func_r;

endmodule

FILE: hw/rtl/lruhc_ctrl.sv
// ----------------------------------------------------------------------------
// lruhc_ctrl
// Sequencer: accepts an item, runs the datapath's clear sweep or search sweep
// (then update, bar a release miss; none for a no-op), then strobes the result.
// ----------------------------------------------------------------------------
module lruhc_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  output lruhc_pkg::lruhc_cmd_t  cmd,
  input  lruhc_pkg::lruhc_sts_t  sts
);
  import lruhc_pkg::*;

  typedef enum logic [3:0] {
    S_INIT,
    S_INIT_WAIT,
    S_IDLE,
    S_DISPATCH,
    S_SEARCH,
    S_DECIDED,
    S_UPDATE,
    S_CLR_WAIT,
    S_FINISH
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r) inside
      S_INIT: begin
        cmd.clr_start = 1'b1;
        state_nxt     = S_INIT_WAIT;
      end
      S_INIT_WAIT: begin
        if (!sts.pass_busy) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (sts.func) inside
          FUNC_ACQUIRE, FUNC_RELEASE: begin
            cmd.scan_start = 1'b1;
            state_nxt      = S_SEARCH;
          end
          FUNC_CLEAR: begin
            cmd.clr_start = 1'b1;
            cmd.decide    = 1'b1;
            state_nxt     = S_CLR_WAIT;
          end
          default: begin
            cmd.decide = 1'b1;
            state_nxt  = S_FINISH;
          end
        endcase
      end
      S_SEARCH: begin
        if (!sts.pass_busy) begin
          cmd.decide = 1'b1;
          state_nxt  = S_DECIDED;
        end
      end
      S_DECIDED: begin
        // release miss leaves the memories untouched
        if (sts.func == FUNC_ACQUIRE || sts.hit) begin
          cmd.upd_start = 1'b1;
          state_nxt     = S_UPDATE;
        end else begin
          state_nxt = S_FINISH;
        end
      end
      S_UPDATE, S_CLR_WAIT: begin
        if (!sts.pass_busy) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        cmd.emit  = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_INIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

`ifndef NO_ASSERTIONS
  a_emit_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> !sts.pass_busy)
    else $error("result strobed while a sweep is running");

  a_busy_fall: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> ($past(cmd.emit) || $past(state_r == S_INIT_WAIT)))
    else $error("busy dropped without a result");

  a_upd_after_decide: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.upd_start |-> $past(cmd.decide))
    else $error("update sweep started without a decision");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy && state_r == S_DISPATCH))
    else $error("accepted item did not start processing");
`endif

endmodule

FILE: hw/rtl/lru_handle_cache.sv
// Throughput: one item at a time, next accept at the edge that takes the result;
// each sweep visits one entry per cycle (1024 entries), search then update.
// Reset: synchronous active-low rst_n, followed by a sweep that invalidates
// every entry; busy stays high until it ends. Results cannot be stalled.
// ----------------------------------------------------------------------------
// lru_handle_cache
// Fully associative cache of tags with least-recently-used replacement.
// ----------------------------------------------------------------------------
module lru_handle_cache (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic [lruhc_pkg::FUNC_W-1:0]       in_func,
  input  logic [lruhc_pkg::KEY_PORT_W-1:0]   in_key,
  output logic                               out_valid,
  output logic                               out_found,
  output logic [lruhc_pkg::SLOT_OUT_W-1:0]   out_slot,
  output logic                               out_evicted,
  output logic [lruhc_pkg::KEY_PORT_W-1:0]   out_evicted_key,
  output logic [lruhc_pkg::OCC_OUT_W-1:0]    out_occupancy
);
  import lruhc_pkg::*;

  lruhc_cmd_t cmd;
  lruhc_sts_t sts;

  lruhc_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .sts   (sts)
  );

  lruhc_datapath u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_func         (in_func),
    .in_key          (in_key),
    .out_valid       (out_valid),
    .out_found       (out_found),
    .out_slot        (out_slot),
    .out_evicted     (out_evicted),
    .out_evicted_key (out_evicted_key),
    .out_occupancy   (out_occupancy)
  );

endmodule

FILE: sim/tb_lru_handle_cache.sv
// ----------------------------------------------------------------------------
// tb_lru_handle_cache
// Self-checking bench for the LRU handle cache. A shadow copy of the tag,
// valid and rank tables predicts every result. Directed items cover the
// corner cases, then random traffic runs on a small working set. The cache
// is then grown with fresh keys, mixed traffic on resident entries follows,
// and a final clear, then acquires and a release of two pool keys, end the run.
// ----------------------------------------------------------------------------
module tb_lru_handle_cache;
  import lruhc_pkg::*;

  localparam int IDLE_PCT   = 24;
  localparam int POOL_SIZE  = 12;
  localparam int MAX_CYCLES = 12_000_000;

  typedef logic [KEY_PORT_W-1:0] key_t;

  typedef struct {
    logic                  found;
    logic [SLOT_OUT_W-1:0] slot;
    logic                  evicted;
    key_t                  evicted_key;
    logic [OCC_OUT_W-1:0]  occupancy;
  } cache_reply_t;

  class cache_shadow;
    key_t         key_mem[CAPACITY];
    bit           valid_mem[CAPACITY];
    int unsigned  rank_mem[CAPACITY];
    int           entries;
    int           errors;
    cache_reply_t replies_due[$];

    function int find_slot(key_t k);
      for (int i = 0; i < CAPACITY; i++)
        if (valid_mem[i] && key_mem[i] == k) return i;
      return CAPACITY;
    endfunction

    // every valid entry more recent than limit gets one step older
    function void age_below(int unsigned limit);
      for (int i = 0; i < CAPACITY; i++)
        if (valid_mem[i] && rank_mem[i] < limit) rank_mem[i]++;
    endfunction

    function void note_item(func_t f, key_t k);
      cache_reply_t r;
      int           s;
      int unsigned  gone_rank;
      r = '{default: '0};
      s = find_slot(k);
      case (f)
        FUNC_ACQUIRE: begin
          if (s < CAPACITY) begin
            r.found = 1'b1;
            age_below(rank_mem[s]);
          end else if (entries >= CAPACITY) begin
            for (s = 0; s < CAPACITY; s++)
              if (valid_mem[s] && rank_mem[s] == CAPACITY - 1) break;
            r.evicted     = 1'b1;
            r.evicted_key = key_mem[s];
            age_below(CAPACITY - 1);
          end else begin
            for (s = 0; s < CAPACITY; s++)
              if (!valid_mem[s]) break;
            age_below(CAPACITY);
            valid_mem[s] = 1'b1;
            entries++;
          end
          key_mem[s]  = k;
          rank_mem[s] = 0;
          r.slot      = SLOT_OUT_W'(s);
        end
        FUNC_RELEASE: begin
          if (s < CAPACITY) begin
            r.found      = 1'b1;
            r.slot       = SLOT_OUT_W'(s);
            valid_mem[s] = 1'b0;
            gone_rank    = rank_mem[s];
            for (int i = 0; i < CAPACITY; i++)
              if (valid_mem[i] && rank_mem[i] > gone_rank) rank_mem[i]--;
            entries--;
          end
        end
        FUNC_CLEAR: begin
          foreach (valid_mem[i]) valid_mem[i] = 1'b0;
          entries = 0;
        end
        default: ;
      endcase
      r.occupancy = OCC_OUT_W'(entries);
      replies_due = {replies_due, r};
    endfunction

    function void check_result(logic found, logic [SLOT_OUT_W-1:0] slot, logic evicted,
                               key_t evicted_key, logic [OCC_OUT_W-1:0] occupancy);
      cache_reply_t e;
      if (replies_due.size() == 0) begin
        $error("result with no item pending");
        errors++;
        return;
      end
      e = replies_due.pop_front();
      if (found !== e.found) begin
        $error("out_found: expected %0d, got %0d", e.found, found);
        errors++;
      end
      if (slot !== e.slot) begin
        $error("out_slot: expected %0d, got %0d", e.slot, slot);
        errors++;
      end
      if (evicted !== e.evicted) begin
        $error("out_evicted: expected %0d, got %0d", e.evicted, evicted);
        errors++;
      end
      if (evicted_key !== e.evicted_key) begin
        $error("out_evicted_key: expected %h, got %h", e.evicted_key, evicted_key);
        errors++;
      end
      if (occupancy !== e.occupancy) begin
        $error("out_occupancy: expected %0d, got %0d", e.occupancy, occupancy);
        errors++;
      end
    endfunction

    function key_t pick_resident();
      int i;
      if (entries == 0) return {$urandom(), $urandom()};
      do i = $urandom_range(CAPACITY - 1); while (!valid_mem[i]);
      return key_mem[i];
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic [FUNC_W-1:0]     in_func = FUNC_NOP;
  key_t                  in_key = '0;
  logic                  busy;
  logic                  out_valid;
  logic                  out_found;
  logic [SLOT_OUT_W-1:0] out_slot;
  logic                  out_evicted;
  key_t                  out_evicted_key;
  logic [OCC_OUT_W-1:0]  out_occupancy;

  cache_shadow shadow = new();
  bit          quiet = 1'b0;
  int          cycles = 0;
  key_t        pool[POOL_SIZE];

  lru_handle_cache i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_func         (in_func),
    .in_key          (in_key),
    .out_valid       (out_valid),
    .out_found       (out_found),
    .out_slot        (out_slot),
    .out_evicted     (out_evicted),
    .out_evicted_key (out_evicted_key),
    .out_occupancy   (out_occupancy)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= MAX_CYCLES) begin
      $display("Mismatches found");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid)
      shadow.check_result(out_found, out_slot, out_evicted, out_evicted_key, out_occupancy);
  end

  function automatic key_t fresh_key();
    return {$urandom(), $urandom()};
  endfunction

  // start may drop at random, also while the block is busy, unless quiet is set
  task automatic issue(func_t f, key_t k);
    logic go;
    in_func <= f;
    in_key  <= k;
    forever begin
      go = quiet || ($urandom_range(99) >= IDLE_PCT);
      start <= go;
      @(posedge clk);
      if (go && !busy) break;
    end
    shadow.note_item(f, k);
  endtask

  task automatic pool_traffic(int n);
    int   r;
    key_t k;
    for (int i = 0; i < n; i++) begin
      quiet = (i >= 50 && i < 100);
      k = ($urandom_range(99) < 75) ? pool[$urandom_range(POOL_SIZE - 1)] : fresh_key();
      r = $urandom_range(99);
      if (r < 58)      issue(FUNC_ACQUIRE, k);
      else if (r < 88) issue(FUNC_RELEASE, k);
      else if (r < 94) issue(FUNC_CLEAR, fresh_key());
      else             issue(FUNC_NOP, k);
    end
    quiet = 1'b0;
  endtask

  // resident entries mixed with fresh keys; releases open holes that misses refill
  task automatic full_traffic(int n);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 40)      issue(FUNC_ACQUIRE, fresh_key());
      else if (r < 70) issue(FUNC_ACQUIRE, shadow.pick_resident());
      else if (r < 85) issue(FUNC_RELEASE, shadow.pick_resident());
      else if (r < 91) issue(FUNC_RELEASE, fresh_key());
      else             issue(FUNC_NOP, shadow.pick_resident());
    end
  endtask

  initial begin
    foreach (pool[i]) pool[i] = fresh_key();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed corners
    issue(FUNC_NOP, '0);
    issue(FUNC_RELEASE, '1);
    issue(FUNC_ACQUIRE, '0);
    issue(FUNC_ACQUIRE, '1);
    issue(FUNC_ACQUIRE, 64'h8000_0000_0000_0000);
    issue(FUNC_ACQUIRE, '0);
    issue(FUNC_RELEASE, '1);
    issue(FUNC_RELEASE, '1);
    issue(FUNC_ACQUIRE, 64'h0000_0000_0000_0001);
    issue(FUNC_ACQUIRE, '1);
    issue(FUNC_ACQUIRE, 64'h8000_0000_0000_0000);
    issue(FUNC_RELEASE, '0);
    issue(FUNC_NOP, '1);
    issue(FUNC_CLEAR, '1);
    issue(FUNC_ACQUIRE, '0);
    issue(FUNC_RELEASE, '1);
    issue(FUNC_CLEAR, '0);
    issue(FUNC_CLEAR, '0);
    issue(FUNC_NOP, 64'h5555_aaaa_5555_aaaa);

    pool_traffic(150);

    repeat (50) issue(FUNC_ACQUIRE, fresh_key());
    full_traffic(65);

    issue(FUNC_CLEAR, fresh_key());
    issue(FUNC_ACQUIRE, pool[0]);
    issue(FUNC_ACQUIRE, pool[1]);
    issue(FUNC_ACQUIRE, pool[0]);
    issue(FUNC_RELEASE, pool[1]);
    start <= 1'b0;

    while (shadow.replies_due.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);
    if (shadow.errors == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

FILE: lru_handle_cache.f
hw/rtl/lruhc_pkg.sv
hw/rtl/lruhc_datapath.sv
hw/rtl/lruhc_ctrl.sv
hw/rtl/lru_handle_cache.sv
sim/tb_lru_handle_cache.sv
